### design/assert_macros.svh
// Assertion macros for the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`else

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### design/mdgs_pkg.sv
// Constants, register indexes and exp lookup tables for the Metropolis step block.
`default_nettype none

package mdgs_pkg;

    localparam int POS_W           = 24;
    localparam int CNT_W           = 32;
    localparam int STEP_W          = 23;
    localparam int K_W             = 24;
    localparam int RAND_W          = 16;
    localparam int CFG_W           = 24;
    localparam int CFG_IDX_W       = 2;

    // exp tables; depth must be a power of two
    localparam int EXP_TABLE_DEPTH = 256;
    localparam int EXP_TAB_LOG     = $clog2(EXP_TABLE_DEPTH);
    localparam int LOW_W           = 16 - EXP_TAB_LOG;
    localparam int LOW_DEPTH       = 1 << LOW_W;
    localparam int INT_STEPS       = 16;
    localparam int SERIES_TERMS    = 12;
    localparam longint unsigned ONE_Q30 = 64'd1 << 30;

    localparam logic [STEP_W-1:0]   STEP_SIZE_RST = 23'd1048576;
    localparam logic [POS_W-1:0]    PEAK_OFF_RST  = 24'd1048576;
    localparam logic [K_W-1:0]      INV_2S2_RST   = 24'd32768;
    localparam logic [POS_W-1:0]    START_POS_RST = 24'd0;
    localparam logic [CNT_W-1:0]    CNT_MAX       = {CNT_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_SIZE        = 2'd0,
        REG_PEAK_OFFSET      = 2'd1,
        REG_INV_TWO_SIGMA_SQ = 2'd2,
        REG_START_POSITION   = 2'd3
    } t_reg_idx;

    typedef logic [30:0] t_q30;
    typedef t_q30 t_int_tab  [INT_STEPS];
    typedef t_q30 t_frac_tab [EXP_TABLE_DEPTH];
    typedef t_q30 t_low_tab  [LOW_DEPTH];

    // floor(n / d) by shift and subtract, used only by the table builders
    function automatic longint unsigned udiv(input longint unsigned n,
                                             input longint unsigned d);
        longint unsigned q;
        longint unsigned rem;
        q   = 64'd0;
        rem = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            rem = (rem << 1) | ((n >> b) & 64'd1);
            if (rem >= d) begin
                rem = rem - d;
                q   = q | (64'd1 << b);
            end
        end
        return q;
    endfunction

    // exp(-t) for t in [0,1], Q1.30, 12-term Horner form
    function automatic longint unsigned exp_series(input longint unsigned t);
        longint unsigned h;
        h = ONE_Q30;
        for (int m = SERIES_TERMS; m >= 1; m--) begin
            h = ONE_Q30 - udiv((t * h) >> 30, 64'(m));
        end
        return h;
    endfunction

    function automatic t_int_tab build_int_tab();
        t_int_tab        tab;
        longint unsigned e1;
        longint unsigned v;
        e1 = exp_series(ONE_Q30);
        v  = ONE_Q30;
        for (int i = 0; i < INT_STEPS; i++) begin
            tab[i] = t_q30'(v);
            v      = (v * e1) >> 30;
        end
        return tab;
    endfunction

    function automatic t_frac_tab build_frac_tab();
        t_frac_tab tab;
        for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
            tab[i] = t_q30'(exp_series(longint'(i) << (30 - EXP_TAB_LOG)));
        end
        return tab;
    endfunction

    // residual fraction below one table step, scaled to Q.30 by << 14
    function automatic t_low_tab build_low_tab();
        t_low_tab tab;
        for (int i = 0; i < LOW_DEPTH; i++) begin
            tab[i] = t_q30'(exp_series(longint'(i) << 14));
        end
        return tab;
    endfunction

    localparam t_int_tab  INT_TAB  = build_int_tab();
    localparam t_frac_tab FRAC_TAB = build_frac_tab();
    localparam t_low_tab  LOW_TAB  = build_low_tab();

endpackage

`default_nettype wire

### design/metropolis_double_gaussian_step.sv
// Top level: one Metropolis step per item on a shared multiplier.
//
// Usage
//   Input channel s_axis: tdata = {accept_rand, step_rand} (step_rand lowest),
//   tuser = restart. A restart item reloads start_position and zeroes both
//   counts before its step is taken.
//   Output channel m_axis: tdata = {attempted_total, accepted_total,
//   new_position} (new_position lowest), tuser = moved. One result per item.
//   Config port: i_cfg_we / i_cfg_idx / i_cfg_data, one register per write,
//   only while no item is in flight.
// Timing
//   The sequencer drives a single 34x34 signed multiplier, one product per
//   cycle. A step takes a step product, a candidate state, 4 gaussian terms
//   (DIFF, SQR, SCALE, LOOK, MULF, MULG, ACCUM), 2 density squares (DENS,
//   DSTORE), an acceptance product (CMP) and a decision state (DEC): the
//   result is registered on leaving DEC and s_axis_tready rises at that same
//   edge, so a new item is taken only once the last step has left DEC; a
//   stalled output holds the step in DEC.
// Reset and stall
//   i_rst_n (synchronous, active low) zeroes position and counts and loads the
//   register reset values. The output register holds a result until taken; a
//   finished step waits in its last state while the previous result is
//   still held, so nothing is lost.
`default_nettype none

module metropolis_double_gaussian_step (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration write port
    input  wire logic                          i_cfg_we,
    input  wire logic [mdgs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [mdgs_pkg::CFG_W-1:0]    i_cfg_data,
    // input items
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [31:0]                   s_axis_tdata,  // step_rand, accept_rand
    input  wire logic                          s_axis_tuser,  // restart
    // result items
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [87:0]                        m_axis_tdata,  // new_position,
                                                              // accepted_total,
                                                              // attempted_total
    output logic                               m_axis_tuser   // moved
);
    import mdgs_pkg::*;

    typedef enum logic [13:0] {
        ST_IDLE   = 14'b00000000000001,
        ST_STEP   = 14'b00000000000010,
        ST_CAND   = 14'b00000000000100,
        ST_DIFF   = 14'b00000000001000,
        ST_SQR    = 14'b00000000010000,
        ST_SCALE  = 14'b00000000100000,
        ST_LOOK   = 14'b00000001000000,
        ST_MULF   = 14'b00000010000000,
        ST_MULG   = 14'b00000100000000,
        ST_ACCUM  = 14'b00001000000000,
        ST_DENS   = 14'b00010000000000,
        ST_DSTORE = 14'b00100000000000,
        ST_CMP    = 14'b01000000000000,
        ST_DEC    = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [STEP_W-1:0] r_step_size;
    logic [POS_W-1:0]  r_peak_off;
    logic [K_W-1:0]    r_inv_2s2;
    logic [POS_W-1:0]  r_start_pos;

    // walker state
    logic [POS_W-1:0]  r_x;
    logic [CNT_W-1:0]  r_acc_cnt;
    logic [CNT_W-1:0]  r_att_cnt;

    // work registers
    logic [RAND_W-1:0] r_u;
    logic [RAND_W-1:0] r_p;
    logic [POS_W-1:0]  r_cand;
    logic [1:0]        r_term;      // bit0: +mu, bit1: candidate position
    logic [24:0]       r_ad;
    logic              r_big;
    t_q30              r_ti, r_tf, r_tg;
    logic [31:0]       r_esum;
    logic [32:0]       r_s_old, r_s_new;
    logic signed [67:0] r_prod;

    // output register
    logic              r_out_valid;
    logic [POS_W-1:0]  r_out_pos;
    logic              r_out_moved;
    logic [CNT_W-1:0]  r_out_acc;
    logic [CNT_W-1:0]  r_out_att;

    // shared multiplier
    logic signed [33:0] w_ma, w_mb;
    logic signed [67:0] w_prod;
    logic               w_mul_en;

    logic               w_in_acc;
    logic               w_out_free;
    logic               w_acc;

    logic signed [25:0] w_stepv;
    logic signed [26:0] w_sum;
    logic [POS_W-1:0]   w_sat;
    logic signed [25:0] w_pos26, w_mu26, w_d;
    logic [32:0]        w_a;
    logic [30:0]        w_e;
    logic [31:0]        w_esum_nx;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_att, r_out_acc, r_out_pos};
    assign m_axis_tuser  = r_out_moved;

    // operand select for the one multiplier
    always_comb begin
        w_ma     = '0;
        w_mb     = '0;
        w_mul_en = 1'b1;
        case (r_state)
            ST_STEP: begin
                w_ma = 34'(signed'(r_u));
                w_mb = {11'b0, r_step_size};
            end
            ST_SQR: begin
                w_ma = {9'b0, r_ad};
                w_mb = {9'b0, r_ad};
            end
            ST_SCALE: begin
                w_ma = {5'b0, r_prod[48:20]};
                w_mb = {10'b0, r_inv_2s2};
            end
            ST_MULF: begin
                w_ma = {3'b0, r_ti};
                w_mb = {3'b0, r_tf};
            end
            ST_MULG: begin
                w_ma = {3'b0, r_prod[60:30]};
                w_mb = {3'b0, r_tg};
            end
            ST_DENS: begin
                w_ma = {2'b0, r_esum};
                w_mb = {2'b0, r_esum};
            end
            ST_CMP: begin
                w_ma = {18'b0, r_p};
                w_mb = {1'b0, r_s_old};
            end
            default: begin
                w_mul_en = 1'b0;
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;

    // candidate: floor(u*delta / 2^15) added to x, saturated
    assign w_stepv = r_prod[40:15];
    assign w_sum   = 27'(signed'(r_x)) + 27'(w_stepv);
    always_comb begin
        if (w_sum > 27'sd8388607) begin
            w_sat = 24'h7FFFFF;
        end else if (w_sum < -27'sd8388608) begin
            w_sat = 24'h800000;
        end else begin
            w_sat = w_sum[POS_W-1:0];
        end
    end

    // distance to one of the two peaks
    assign w_pos26 = 26'(signed'(r_term[1] ? r_cand : r_x));
    assign w_mu26  = 26'(signed'(r_peak_off));
    assign w_d     = r_term[0] ? (w_pos26 + w_mu26) : (w_pos26 - w_mu26);

    assign w_a       = r_prod[52:20];                 // Q17.16 exponent argument
    assign w_e       = r_big ? 31'd0 : r_prod[60:30];
    assign w_esum_nx = r_term[0] ? (r_esum + {1'b0, w_e}) : {1'b0, w_e};

    assign w_acc = r_prod[48:0] < {r_s_new, 16'b0};

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (w_in_acc) begin
                           n_state = ST_STEP;
                       end
            ST_STEP:   n_state = ST_CAND;
            ST_CAND:   n_state = ST_DIFF;
            ST_DIFF:   n_state = ST_SQR;
            ST_SQR:    n_state = ST_SCALE;
            ST_SCALE:  n_state = ST_LOOK;
            ST_LOOK:   n_state = ST_MULF;
            ST_MULF:   n_state = ST_MULG;
            ST_MULG:   n_state = ST_ACCUM;
            ST_ACCUM:  n_state = r_term[0] ? ST_DENS : ST_DIFF;
            ST_DENS:   n_state = ST_DSTORE;
            ST_DSTORE: n_state = r_term[1] ? ST_CMP : ST_DIFF;
            ST_CMP:    n_state = ST_DEC;
            ST_DEC:    if (w_out_free) begin
                           n_state = ST_IDLE;
                       end
            default:   n_state = ST_IDLE;
        endcase
    end

    // control and walker state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step_size <= STEP_SIZE_RST;
            r_peak_off  <= PEAK_OFF_RST;
            r_inv_2s2   <= INV_2S2_RST;
            r_start_pos <= START_POS_RST;
            r_x         <= '0;
            r_acc_cnt   <= '0;
            r_att_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_STEP_SIZE:        r_step_size <= i_cfg_data[STEP_W-1:0];
                    REG_PEAK_OFFSET:      r_peak_off  <= i_cfg_data;
                    REG_INV_TWO_SIGMA_SQ: r_inv_2s2   <= i_cfg_data;
                    REG_START_POSITION:   r_start_pos <= i_cfg_data;
                    default: ;
                endcase
            end

            if (w_in_acc && s_axis_tuser) begin
                r_x       <= r_start_pos;
                r_acc_cnt <= '0;
                r_att_cnt <= '0;
            end

            if (r_state == ST_DEC && w_out_free) begin
                if (w_acc) begin
                    r_x <= r_cand;
                    if (r_acc_cnt != CNT_MAX) begin
                        r_acc_cnt <= r_acc_cnt + 1'b1;
                    end
                end
                if (r_att_cnt != CNT_MAX) begin
                    r_att_cnt <= r_att_cnt + 1'b1;
                end
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_mul_en) begin
            r_prod <= w_prod;
        end
        case (r_state)
            ST_IDLE: begin
                r_u    <= s_axis_tdata[15:0];
                r_p    <= s_axis_tdata[31:16];
                r_term <= 2'd0;
            end
            ST_CAND: begin
                r_cand <= w_sat;
            end
            ST_DIFF: begin
                r_ad <= w_d[25] ? 25'(-w_d) : w_d[24:0];
            end
            ST_LOOK: begin
                r_big <= |w_a[32:20];
                r_ti  <= INT_TAB[w_a[19:16]];
                r_tf  <= FRAC_TAB[w_a[15 -: EXP_TAB_LOG]];
                r_tg  <= LOW_TAB[w_a[LOW_W-1:0]];
            end
            ST_ACCUM: begin
                r_esum <= w_esum_nx;
                if (!r_term[0]) begin
                    r_term <= r_term + 2'd1;
                end
            end
            ST_DSTORE: begin
                if (r_term[1]) begin
                    r_s_new <= r_prod[62:30];
                end else begin
                    r_s_old <= r_prod[62:30];
                    r_term  <= r_term + 2'd1;
                end
            end
            default: ;
        endcase
        if (r_state == ST_DEC && w_out_free) begin
            r_out_pos   <= w_acc ? r_cand : r_x;
            r_out_moved <= w_acc;
            r_out_acc   <= (w_acc && r_acc_cnt != CNT_MAX) ? r_acc_cnt + 1'b1 : r_acc_cnt;
            r_out_att   <= (r_att_cnt != CNT_MAX) ? r_att_cnt + 1'b1 : r_att_cnt;
        end
    end

    `include "assert_macros.svh"

    `ASSERT_NXT(a_accept_starts, i_clk, i_rst_n, w_in_acc, r_state == ST_STEP)
    `ASSERT_IMP(a_cmp_after_all_terms, i_clk, i_rst_n, r_state == ST_CMP, r_term == 2'd3)
    `ASSERT_IMP(a_counts_order, i_clk, i_rst_n, r_out_valid, r_out_acc <= r_out_att)
    `ASSERT_NXT(a_reject_keeps_pos, i_clk, i_rst_n,
                r_state == ST_DEC && w_out_free && !w_acc, $stable(r_x))

endmodule

`default_nettype wire
